// ===== src/br1ld_pkg.sv =====
// br1ld_pkg: shared widths, limits, register indexes and control structs
// for the byterun1 line decoder; no dependencies
package br1ld_pkg;

  localparam int unsigned MAX_ROW_BYTES = 1024;
  localparam int unsigned PLANES_LIMIT  = 8;
  localparam int unsigned MAX_ROWS      = 4096;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ROW_BYTES_W = 11;
  localparam int unsigned ROWS_W      = 13;
  localparam int unsigned PLANES_W    = 4;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned COUNT_W     = 2;
  localparam int unsigned TOTAL_W     = 16;
  localparam int unsigned LINE_IDX_W  = 15;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANES     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED = 2'd3;

  // header byte codes
  localparam logic [BYTE_W-1:0] HDR_LIT_MAX = 8'd127;
  localparam logic [BYTE_W-1:0] HDR_NOP     = 8'd128;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input transaction this cycle
    logic run_step;  // emit one result of a repeat run
  } br1ld_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_result;  // next input byte gives a result right away
    logic acc_run;     // next input byte starts a repeat run
    logic run_last;    // current run step is the final one
  } br1ld_sts_t;

endpackage

// ===== src/br1ld_ifs.sv =====
// br1ld_in_if, br1ld_out_if: valid/ready channels of the decoder
// depends on br1ld_pkg
interface br1ld_in_if;
  import br1ld_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface br1ld_out_if;
  import br1ld_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_first;
  logic [BYTE_W-1:0]  out_second;
  logic [COUNT_W-1:0] out_count;
  logic               line_end;
  logic               image_end;
  logic               overrun;
  logic               burst_last;
  modport source (output valid, output out_first, output out_second, output out_count,
                  output line_end, output image_end, output overrun, output burst_last,
                  input ready);
  modport sink   (input valid, input out_first, input out_second, input out_count,
                  input line_end, input image_end, input overrun, input burst_last,
                  output ready);
endinterface

// ===== src/br1ld_ctrl.sv =====
// br1ld_ctrl: handshake controller of the decoder, idle/run state machine
// and output valid; depends on br1ld_pkg
module br1ld_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  br1ld_pkg::br1ld_sts_t sts_i,
  output br1ld_pkg::br1ld_cmd_t cmd_o
);
  import br1ld_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free, accept, run_step, load;

  assign out_free = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept = in_valid_i && in_ready_o;
  assign run_step = (state_q == S_RUN) && out_free;
  assign load = (accept && sts_i.acc_result) || run_step;

  assign cmd_o.accept = accept;
  assign cmd_o.run_step = run_step;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.acc_run) state_d = S_RUN;
      end
      S_RUN: begin
        if (run_step && sts_i.run_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (load) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
    else ovalid_d = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== src/br1ld_dp.sv =====
// br1ld_dp: decoder datapath: configuration registers, header decode,
// line position and index tracking, repeat run counter, output register
// depends on br1ld_pkg
module br1ld_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [br1ld_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [br1ld_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [br1ld_pkg::BYTE_W-1:0]      in_byte_i,
  input  br1ld_pkg::br1ld_cmd_t             cmd_i,
  output br1ld_pkg::br1ld_sts_t             sts_o,
  output logic [br1ld_pkg::BYTE_W-1:0]      out_first_o,
  output logic [br1ld_pkg::BYTE_W-1:0]      out_second_o,
  output logic [br1ld_pkg::COUNT_W-1:0]     out_count_o,
  output logic                              line_end_o,
  output logic                              image_end_o,
  output logic                              overrun_o,
  output logic                              burst_last_o
);
  import br1ld_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT, PH_DROP} phase_e;

  logic [ROW_BYTES_W-1:0] row_bytes_q;
  logic [ROWS_W-1:0]      rows_q;
  logic [PLANES_W-1:0]    planes_q;
  logic                   compressed_q;

  phase_e                 phase_q, phase_d;
  logic [BYTE_W-1:0]      lit_left_q, lit_left_d;
  logic [ROW_BYTES_W-1:0] line_pos_q, line_pos_d;
  logic [LINE_IDX_W-1:0]  line_idx_q, line_idx_d;
  logic [BYTE_W-1:0]      run_left_q, run_left_d;
  logic                   run_over_q, run_over_d;
  logic [BYTE_W-1:0]      run_byte_q, run_byte_d;

  logic [BYTE_W-1:0]      out_first_q, out_second_q;
  logic [COUNT_W-1:0]     out_count_q;
  logic                   line_end_q, image_end_q, overrun_q, burst_last_q;

  logic [ROW_BYTES_W-1:0] rb_eff, room;
  logic [ROWS_W-1:0]      rows_eff;
  logic [PLANES_W-1:0]    planes_eff;
  logic [TOTAL_W-1:0]     total;
  logic [ROW_BYTES_W:0]   pos_sum;
  logic [TOTAL_W-1:0]     idx_inc;
  logic [COUNT_W-1:0]     put_n, run_n;
  logic [BYTE_W-1:0]      put_byte, lit_dec, hdr_cnt, run_cnt;
  logic                   put_le, put_ie, do_put, run_last, over;

  // effective geometry, zero acts as one, large values saturate
  always_comb begin
    if (row_bytes_q == '0) rb_eff = ROW_BYTES_W'(1);
    else if (row_bytes_q > ROW_BYTES_W'(MAX_ROW_BYTES)) rb_eff = ROW_BYTES_W'(MAX_ROW_BYTES);
    else rb_eff = row_bytes_q;
    if (rows_q == '0) rows_eff = ROWS_W'(1);
    else if (rows_q > ROWS_W'(MAX_ROWS)) rows_eff = ROWS_W'(MAX_ROWS);
    else rows_eff = rows_q;
    if (planes_q == '0) planes_eff = PLANES_W'(1);
    else if (planes_q > PLANES_W'(PLANES_LIMIT)) planes_eff = PLANES_W'(PLANES_LIMIT);
    else planes_eff = planes_q;
  end

  assign total = TOTAL_W'(rows_eff) * TOTAL_W'(planes_eff);

  assign run_n = (run_left_q >= BYTE_W'(2)) ? COUNT_W'(2) : COUNT_W'(1);
  assign run_last = (run_left_q <= BYTE_W'(2));
  assign lit_dec = lit_left_q - BYTE_W'(1);

  // shared line bookkeeping for one result
  assign do_put = (cmd_i.accept && sts_o.acc_result) || cmd_i.run_step;
  assign put_n = cmd_i.run_step ? run_n : COUNT_W'(1);
  assign put_byte = cmd_i.run_step ? run_byte_q : in_byte_i;
  assign pos_sum = {1'b0, line_pos_q} + (ROW_BYTES_W + 1)'(put_n);
  assign put_le = (pos_sum >= {1'b0, rb_eff});
  assign idx_inc = {1'b0, line_idx_q} + TOTAL_W'(1);
  assign put_ie = put_le && (idx_inc >= total);

  // repeat run sizing against room left in the line
  assign room = (line_pos_q < rb_eff) ? (rb_eff - line_pos_q) : ROW_BYTES_W'(1);
  assign over = (ROW_BYTES_W'(lit_left_q) > room);
  assign run_cnt = over ? room[BYTE_W-1:0] : lit_left_q;
  assign hdr_cnt = BYTE_W'(9'd257 - {1'b0, in_byte_i});

  assign sts_o.acc_result = !compressed_q || (phase_q == PH_LITERAL);
  assign sts_o.acc_run = compressed_q && (phase_q == PH_REPEAT);
  assign sts_o.run_last = run_last;

  always_comb begin
    phase_d    = phase_q;
    lit_left_d = lit_left_q;
    line_pos_d = line_pos_q;
    line_idx_d = line_idx_q;
    run_left_d = run_left_q;
    run_over_d = run_over_q;
    run_byte_d = run_byte_q;

    if (do_put) begin
      if (put_le) begin
        line_pos_d = '0;
        line_idx_d = put_ie ? '0 : idx_inc[LINE_IDX_W-1:0];
      end else begin
        line_pos_d = pos_sum[ROW_BYTES_W-1:0];
      end
    end

    if (cmd_i.accept) begin
      if (!compressed_q) begin
        phase_d    = PH_HEADER;
        lit_left_d = '0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (in_byte_i <= HDR_LIT_MAX) begin
              lit_left_d = in_byte_i + BYTE_W'(1);
              phase_d    = PH_LITERAL;
            end else if (in_byte_i != HDR_NOP) begin
              lit_left_d = hdr_cnt;
              phase_d    = PH_REPEAT;
            end
          end
          PH_LITERAL: begin
            lit_left_d = lit_dec;
            if (lit_dec == '0) phase_d = PH_HEADER;
            else if (put_le) phase_d = PH_DROP;
          end
          PH_DROP: begin
            lit_left_d = lit_dec;
            if (lit_dec == '0) phase_d = PH_HEADER;
          end
          PH_REPEAT: begin
            run_left_d = run_cnt;
            run_over_d = over;
            run_byte_d = in_byte_i;
            lit_left_d = '0;
            phase_d    = PH_HEADER;
          end
          default: phase_d = PH_HEADER;
        endcase
      end
    end

    if (cmd_i.run_step) run_left_d = run_left_q - BYTE_W'(run_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q  <= ROW_BYTES_W'(40);
      rows_q       <= ROWS_W'(1);
      planes_q     <= PLANES_W'(1);
      compressed_q <= 1'b1;
      phase_q      <= PH_HEADER;
      lit_left_q   <= '0;
      line_pos_q   <= '0;
      line_idx_q   <= '0;
      run_left_q   <= '0;
      run_over_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_BYTES:  row_bytes_q  <= cfg_data_i[ROW_BYTES_W-1:0];
          CFG_ROWS:       rows_q       <= cfg_data_i[ROWS_W-1:0];
          CFG_PLANES:     planes_q     <= cfg_data_i[PLANES_W-1:0];
          CFG_COMPRESSED: compressed_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      line_pos_q <= line_pos_d;
      line_idx_q <= line_idx_d;
      run_left_q <= run_left_d;
      run_over_q <= run_over_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    run_byte_q <= run_byte_d;
    if (do_put) begin
      out_first_q  <= put_byte;
      out_second_q <= (put_n == COUNT_W'(2)) ? put_byte : '0;
      out_count_q  <= put_n;
      line_end_q   <= put_le;
      image_end_q  <= put_ie;
      if (cmd_i.run_step) begin
        overrun_q    <= run_last && run_over_q;
        burst_last_q <= run_last;
      end else begin
        overrun_q    <= compressed_q && (lit_dec != '0) && put_le;
        burst_last_q <= 1'b1;
      end
    end
  end

  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;
  assign out_count_o  = out_count_q;
  assign line_end_o   = line_end_q;
  assign image_end_o  = image_end_q;
  assign overrun_o    = overrun_q;
  assign burst_last_o = burst_last_q;

endmodule

// ===== src/byterun1_line_decoder_core.sv =====
// byterun1_line_decoder_core: top level of the packbits line decoder
// depends on br1ld_pkg, br1ld_ifs, br1ld_ctrl, br1ld_dp
// a literal or pass-through byte shows in the output register in the cycle after its accept
// throughput: one input byte per cycle for literal, header and pass-through bytes while the output is not stalled
// a repeat byte holds the input while its run is emitted, two decoded bytes per result, one in the last of an odd run
// reset: async active low, clears handshake state, phase, counters and config to defaults
module byterun1_line_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [br1ld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [br1ld_pkg::CFG_DATA_W-1:0] cfg_data_i,
  br1ld_in_if.sink                         in_i,
  br1ld_out_if.source                      out_o
);
  import br1ld_pkg::*;

  // command and status between controller and datapath
  br1ld_cmd_t cmd;
  br1ld_sts_t sts;

  // controller: input ready, run sequencing, output valid register
  br1ld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: decode state, line tracking and the output payload register
  br1ld_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (in_i.in_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_first_o  (out_o.out_first),
    .out_second_o (out_o.out_second),
    .out_count_o  (out_o.out_count),
    .line_end_o   (out_o.line_end),
    .image_end_o  (out_o.image_end),
    .overrun_o    (out_o.overrun),
    .burst_last_o (out_o.burst_last)
  );

endmodule

// ===== src/br1ld_checker.sv =====
// br1ld_checker: port-level assertions on the decoder output channel,
// bound to byterun1_line_decoder_core; depends on br1ld_pkg
module br1ld_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           valid_i,
  input logic                           ready_i,
  input logic [br1ld_pkg::BYTE_W-1:0]   second_i,
  input logic [br1ld_pkg::COUNT_W-1:0]  count_i,
  input logic                           line_end_i,
  input logic                           image_end_i,
  input logic                           overrun_i
);
  import br1ld_pkg::*;

  // a pending output transaction stays until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i) else $error("output valid dropped while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (count_i == COUNT_W'(1)) || (count_i == COUNT_W'(2)))
    else $error("output count out of range");

  a_image_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && image_end_i |-> line_end_i) else $error("image end without line end");

  a_overrun_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && overrun_i |-> line_end_i) else $error("overrun without line end");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (count_i == COUNT_W'(1)) |-> (second_i == '0))
    else $error("second byte not zero for single-byte result");

endmodule

bind byterun1_line_decoder_core br1ld_checker u_br1ld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (out_o.valid),
  .ready_i     (out_o.ready),
  .second_i    (out_o.out_second),
  .count_i     (out_o.out_count),
  .line_end_i  (out_o.line_end),
  .image_end_i (out_o.image_end),
  .overrun_i   (out_o.overrun)
);
